// ===== sv/urt_pkg.sv =====
// ---------------------------------------------------------------------------
// urt_pkg: shared types and constants of the user region table
// Field widths, table sizing, command and status codes, and the command and
// status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
package urt_pkg;

  // Table sizing
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int ADDR_W     = 47;
  localparam int TOP_W      = 48;
  localparam int END_W      = 49;
  localparam int PAGES_W    = 36;
  localparam int SPAGE_W    = 35;
  localparam int ATTR_W     = 64;
  localparam int LIVE_W     = 5;
  localparam int PAGE_SHIFT = 12;

  // User-accessible page flag, forced on in every stored region
  localparam logic [ATTR_W-1:0] PTE_US = 64'h4;

  typedef enum logic [1:0] {
    OP_RESERVE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_LOOKUP  = 2'd2,
    OP_CLEAR   = 2'd3
  } urt_op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_WINDOW   = 3'd2,
    ST_OVERLAP  = 3'd3,
    ST_FULL     = 3'd4,
    ST_NOTFOUND = 3'd5
  } urt_status_t;

  typedef enum logic {
    CFG_BASE = 1'b0,
    CFG_TOP  = 1'b1
  } urt_cfg_idx_t;

  // One stored region
  typedef struct packed {
    logic [SPAGE_W-1:0] start_page;
    logic [PAGES_W-1:0] page_count;
    logic [ATTR_W-1:0]  attrs;
  } urt_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic        load;
    logic        scan_start;
    logic        scan_step;
    logic        move_rd;
    logic        move_wr;
    logic        append;
    logic        clear;
    logic        finish;
    logic        found_ok;
    urt_status_t status;
  } urt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    urt_op_t op;
    logic    zero_pages;
    logic    out_window;
    logic    hit;
    logic    scan_done;
    logic    full;
    logic    out_free;
  } urt_sts_t;

endpackage

// ===== sv/urt_in_if.sv =====
// ---------------------------------------------------------------------------
// urt_in_if: command channel of the user region table
// Valid/ready channel carrying one command item.
// ---------------------------------------------------------------------------
interface urt_in_if;
  logic                           valid;
  logic                           ready;
  urt_pkg::urt_op_t               cmd;
  logic [urt_pkg::ADDR_W-1:0]     addr;
  logic [urt_pkg::PAGES_W-1:0]    page_count;
  logic [urt_pkg::ATTR_W-1:0]     region_attrs;

  modport source (output valid, cmd, addr, page_count, region_attrs, input ready);
  modport sink   (input valid, cmd, addr, page_count, region_attrs, output ready);
endinterface

// ===== sv/urt_out_if.sv =====
// ---------------------------------------------------------------------------
// urt_out_if: result channel of the user region table
// Valid/ready channel carrying one result item.
// ---------------------------------------------------------------------------
interface urt_out_if;
  logic                           valid;
  logic                           ready;
  urt_pkg::urt_status_t           status;
  logic [urt_pkg::ADDR_W-1:0]     found_start;
  logic [urt_pkg::PAGES_W-1:0]    found_pages;
  logic [urt_pkg::ATTR_W-1:0]     found_attrs;
  logic [urt_pkg::LIVE_W-1:0]     live_count;

  modport source (output valid, status, found_start, found_pages, found_attrs, live_count,
                  input ready);
  modport sink   (input valid, status, found_start, found_pages, found_attrs, live_count,
                  output ready);
endinterface

// ===== sv/urt_cfg_if.sv =====
// ---------------------------------------------------------------------------
// urt_cfg_if: configuration write channel of the user region table
// Valid/ready channel carrying a register index and write data.
// ---------------------------------------------------------------------------
interface urt_cfg_if;
  logic                        valid;
  logic                        ready;
  urt_pkg::urt_cfg_idx_t       index;
  logic [urt_pkg::TOP_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/urt_ram.sv =====
// ---------------------------------------------------------------------------
// urt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module urt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write, then register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/urt_datapath.sv =====
// ---------------------------------------------------------------------------
// urt_datapath: registers, region store and compare logic
// Holds the command item, window registers, region count and result
// register, and scans the region RAM one entry per cycle on command.
// ---------------------------------------------------------------------------
module urt_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  urt_pkg::urt_cmd_t             cmd,
  output urt_pkg::urt_sts_t             sts,
  // command payload
  input  urt_pkg::urt_op_t              in_cmd,
  input  logic [urt_pkg::ADDR_W-1:0]    in_addr,
  input  logic [urt_pkg::PAGES_W-1:0]   in_page_count,
  input  logic [urt_pkg::ATTR_W-1:0]    in_region_attrs,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output urt_pkg::urt_status_t          out_status,
  output logic [urt_pkg::ADDR_W-1:0]    out_found_start,
  output logic [urt_pkg::PAGES_W-1:0]   out_found_pages,
  output logic [urt_pkg::ATTR_W-1:0]    out_found_attrs,
  output logic [urt_pkg::LIVE_W-1:0]    out_live_count,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  urt_pkg::urt_cfg_idx_t         cfg_index,
  input  logic [urt_pkg::TOP_W-1:0]     cfg_data
);

  localparam int AW = urt_pkg::ADDR_W;
  localparam int EW = urt_pkg::END_W;
  localparam int PS = urt_pkg::PAGE_SHIFT;
  localparam int CW = urt_pkg::CNT_W;
  localparam int IW = urt_pkg::IDX_W;

  // Item registers
  urt_pkg::urt_op_t              op_r;
  logic [AW-1:0]                 addr_r;
  logic [urt_pkg::PAGES_W-1:0]   pages_r;
  logic [urt_pkg::ATTR_W-1:0]    attrs_r;
  logic [EW-1:0]                 end_r;
  logic [AW-1:0]                 start_w;
  logic [EW-1:0]                 end_nxt;

  // Window registers
  logic [AW-1:0]                 base_r;
  logic [urt_pkg::TOP_W-1:0]     top_r;

  // Table control
  logic [CW-1:0]                 total_r;
  logic [CW-1:0]                 iss_idx_r;
  logic                          chk_vld_r;
  logic [IW-1:0]                 chk_idx_r;
  logic [IW-1:0]                 hit_idx_r;
  logic                          issue;
  logic [CW-1:0]                 last_cnt;

  // Found region
  logic [AW-1:0]                 fnd_start_r;
  logic [urt_pkg::PAGES_W-1:0]   fnd_pages_r;
  logic [urt_pkg::ATTR_W-1:0]    fnd_attrs_r;

  // Result register
  logic                          out_valid_r;
  urt_pkg::urt_status_t          out_status_r;
  logic [AW-1:0]                 out_start_r;
  logic [urt_pkg::PAGES_W-1:0]   out_pages_r;
  logic [urt_pkg::ATTR_W-1:0]    out_attrs_r;
  logic [urt_pkg::LIVE_W-1:0]    out_live_r;

  // RAM ports
  logic                          ram_we;
  logic [IW-1:0]                 ram_waddr;
  urt_pkg::urt_entry_t           ram_wdata;
  logic                          ram_re;
  logic [IW-1:0]                 ram_raddr;
  urt_pkg::urt_entry_t           ram_rdata;

  // Compare terms for the entry under check
  logic [AW-1:0]                 ent_begin;
  logic [EW-1:0]                 ent_end;
  logic                          match;

  assign start_w = {addr_r[AW-1:PS], PS'(0)};
  assign end_nxt = {2'b00, in_addr[AW-1:PS], PS'(0)} + {1'b0, in_page_count, PS'(0)};

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_cmd;
      addr_r  <= in_addr;
      pages_r <= in_page_count;
      attrs_r <= in_region_attrs;
      end_r   <= end_nxt;
    end
  end

  // Window registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= AW'(64'h40_0000);
      top_r  <= urt_pkg::TOP_W'(64'h7FFF_FFFF_F000);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        urt_pkg::CFG_BASE: base_r <= cfg_data[AW-1:0];
        urt_pkg::CFG_TOP:  top_r  <= cfg_data;
      endcase
    end
  end

  // Entry compare
  assign ent_begin = {ram_rdata.start_page, PS'(0)};
  assign ent_end   = {2'b00, ent_begin} + {1'b0, ram_rdata.page_count, PS'(0)};

  always_comb begin
    unique case (op_r)
      urt_pkg::OP_RESERVE: match = ({2'b00, start_w} < ent_end) && (end_r > {2'b00, ent_begin});
      urt_pkg::OP_RELEASE: match = (ent_begin == start_w);
      urt_pkg::OP_LOOKUP:  match = (addr_r >= ent_begin) && ({2'b00, addr_r} < ent_end);
      urt_pkg::OP_CLEAR:   match = 1'b0;
    endcase
  end

  // Scan: issue one read per cycle, check the entry read the cycle before
  assign issue    = cmd.scan_step && (iss_idx_r < total_r);
  assign last_cnt = total_r - CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_idx_r <= '0;
      chk_vld_r <= 1'b0;
    end else if (cmd.scan_start) begin
      iss_idx_r <= '0;
      chk_vld_r <= 1'b0;
    end else if (cmd.scan_step) begin
      chk_vld_r <= issue;
      if (issue) begin
        iss_idx_r <= iss_idx_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      chk_idx_r <= iss_idx_r[IW-1:0];
    end
    if (cmd.scan_step && sts.hit) begin
      hit_idx_r   <= chk_idx_r;
      fnd_start_r <= ent_begin;
      fnd_pages_r <= ram_rdata.page_count;
      fnd_attrs_r <= ram_rdata.attrs;
    end
  end

  // Region count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (cmd.append) begin
      total_r <= total_r + CW'(1);
    end else if (cmd.move_wr) begin
      total_r <= last_cnt;
    end else if (cmd.clear) begin
      total_r <= '0;
    end
  end

  // Region RAM ports
  assign ram_re    = issue || cmd.move_rd;
  assign ram_raddr = cmd.move_rd ? last_cnt[IW-1:0] : iss_idx_r[IW-1:0];
  assign ram_we    = cmd.append || cmd.move_wr;
  assign ram_waddr = cmd.append ? total_r[IW-1:0] : hit_idx_r;

  always_comb begin
    if (cmd.append) begin
      ram_wdata.start_page = addr_r[AW-1:PS];
      ram_wdata.page_count = pages_r;
      ram_wdata.attrs      = attrs_r | urt_pkg::PTE_US;
    end else begin
      ram_wdata = ram_rdata;
    end
  end

  urt_ram #(
    .WIDTH ($bits(urt_pkg::urt_entry_t)),
    .DEPTH (urt_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= cmd.status;
      out_start_r  <= cmd.found_ok ? fnd_start_r : '0;
      out_pages_r  <= cmd.found_ok ? fnd_pages_r : '0;
      out_attrs_r  <= cmd.found_ok ? fnd_attrs_r : '0;
      out_live_r   <= cmd.clear ? '0 : urt_pkg::LIVE_W'(total_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_start = out_start_r;
  assign out_found_pages = out_pages_r;
  assign out_found_attrs = out_attrs_r;
  assign out_live_count  = out_live_r;

  // Status to the controller
  assign sts.op         = op_r;
  assign sts.zero_pages = (pages_r == '0);
  assign sts.out_window = (start_w < base_r) || (end_r > {1'b0, top_r});
  assign sts.hit        = chk_vld_r && match;
  assign sts.scan_done  = !chk_vld_r && !(iss_idx_r < total_r);
  assign sts.full       = (total_r >= CW'(urt_pkg::TABLE_DEPTH));
  assign sts.out_free   = !out_valid_r || out_ready;

endmodule

// ===== sv/urt_ctrl.sv =====
// ---------------------------------------------------------------------------
// urt_ctrl: command sequencer of the user region table
// Accepts one item, runs the checks, the table scan and the slot move,
// picks the result status and hands the result to the output register.
// ---------------------------------------------------------------------------
module urt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  urt_pkg::urt_sts_t   sts,
  output urt_pkg::urt_cmd_t   cmd
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_CHECK   = 6'b000010,
    S_SCAN    = 6'b000100,
    S_MOVE_RD = 6'b001000,
    S_MOVE_WR = 6'b010000,
    S_FIN     = 6'b100000
  } urt_state_t;

  urt_state_t           state_r, state_nxt;
  urt_pkg::urt_status_t st_r, st_nxt;
  logic                 found_ok_r, found_ok_nxt;

  // Next state and commands
  always_comb begin
    state_nxt      = state_r;
    st_nxt         = st_r;
    found_ok_nxt   = found_ok_r;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.status     = st_r;
    cmd.found_ok   = found_ok_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load     = 1'b1;
          found_ok_nxt = 1'b0;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        unique case (sts.op)
          urt_pkg::OP_RESERVE: begin
            priority if (sts.zero_pages) begin
              st_nxt    = urt_pkg::ST_ZERO;
              state_nxt = S_FIN;
            end else if (sts.out_window) begin
              st_nxt    = urt_pkg::ST_WINDOW;
              state_nxt = S_FIN;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          urt_pkg::OP_RELEASE, urt_pkg::OP_LOOKUP: begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
          urt_pkg::OP_CLEAR: begin
            st_nxt    = urt_pkg::ST_OK;
            state_nxt = S_FIN;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        priority if (sts.hit) begin
          unique case (sts.op)
            urt_pkg::OP_RESERVE: begin
              st_nxt    = urt_pkg::ST_OVERLAP;
              state_nxt = S_FIN;
            end
            urt_pkg::OP_RELEASE: begin
              state_nxt = S_MOVE_RD;
            end
            urt_pkg::OP_LOOKUP: begin
              st_nxt       = urt_pkg::ST_OK;
              found_ok_nxt = 1'b1;
              state_nxt    = S_FIN;
            end
            urt_pkg::OP_CLEAR: begin
              state_nxt = S_FIN;
            end
          endcase
        end else if (sts.scan_done) begin
          state_nxt = S_FIN;
          if (sts.op == urt_pkg::OP_RESERVE) begin
            if (sts.full) begin
              st_nxt = urt_pkg::ST_FULL;
            end else begin
              cmd.append = 1'b1;
              st_nxt     = urt_pkg::ST_OK;
            end
          end else begin
            st_nxt = urt_pkg::ST_NOTFOUND;
          end
        end
      end
      S_MOVE_RD: begin
        // fetch the last entry
        cmd.move_rd = 1'b1;
        state_nxt   = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        // drop it into the freed slot
        cmd.move_wr = 1'b1;
        st_nxt      = urt_pkg::ST_OK;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          cmd.clear  = (sts.op == urt_pkg::OP_CLEAR);
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      st_r       <= urt_pkg::ST_OK;
      found_ok_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      st_r       <= st_nxt;
      found_ok_r <= found_ok_nxt;
    end
  end

endmodule

// ===== sv/user_region_table.sv =====
// ---------------------------------------------------------------------------
// user_region_table: table of user virtual-address regions
// Reserve, release, lookup and clear of up to TABLE_DEPTH page regions.
// ---------------------------------------------------------------------------
// The block takes one command item at a time and returns one result item per
// command. The time from acceptance to result grows with the number of regions
// held and is shorter when a lookup, release or overlap hits early; clear, and
// a reserve rejected for zero pages or for the window, skip the scan. Any wait
// on the output adds to the time. The scan is bound by the single read port of
// the region RAM, which it walks one entry per cycle. The next command is
// accepted while a finished result still waits on the output.
// Window registers are written through the configuration channel, which is
// always ready; write them only while idle.
// ---------------------------------------------------------------------------
module user_region_table (
  input  logic      clk,
  input  logic      rst_n,
  urt_in_if.sink    in_ch,
  urt_out_if.source out_ch,
  urt_cfg_if.sink   cfg_ch
);

  urt_pkg::urt_cmd_t ctrl_cmd;
  urt_pkg::urt_sts_t dp_sts;

  urt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (dp_sts),
    .cmd      (ctrl_cmd)
  );

  urt_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (ctrl_cmd),
    .sts             (dp_sts),
    .in_cmd          (in_ch.cmd),
    .in_addr         (in_ch.addr),
    .in_page_count   (in_ch.page_count),
    .in_region_attrs (in_ch.region_attrs),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_found_start (out_ch.found_start),
    .out_found_pages (out_ch.found_pages),
    .out_found_attrs (out_ch.found_attrs),
    .out_live_count  (out_ch.live_count),
    .cfg_valid       (cfg_ch.valid),
    .cfg_ready       (cfg_ch.ready),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data)
  );

`ifndef SYNTH
  // Never append into a full table
  a_no_append_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.append |-> !dp_sts.full)
    else $error("append issued on a full table");

  // Hand over a result only when the output register can take it
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.finish |-> dp_sts.out_free)
    else $error("result finished while output register busy");

  // An accepted item keeps the input closed in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input reopened right after accept");

  // A new result appears only after a finish
  a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(ctrl_cmd.finish))
    else $error("result valid without finish");
`endif

endmodule

// ===== bench/urt_region_checker.sv =====
// ---------------------------------------------------------------------------
// urt_region_checker: result checker of the user region table
// Watches the command, result and configuration channels, keeps its own copy
// of the region table and the user window, predicts one result item per
// accepted command item and compares each accepted result field by field.
// ---------------------------------------------------------------------------
module urt_region_checker (
  input  logic clk,
  input  logic rst_n,
  urt_in_if    in_ch,
  urt_out_if   out_ch,
  urt_cfg_if   cfg_ch,
  output int   fail_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import urt_pkg::*;

  typedef struct packed {
    urt_status_t        status;
    logic [ADDR_W-1:0]  found_start;
    logic [PAGES_W-1:0] found_pages;
    logic [ATTR_W-1:0]  found_attrs;
    logic [LIVE_W-1:0]  live_count;
  } region_reply_t;

  // Shadow table and window
  logic [SPAGE_W-1:0] slot_page  [TABLE_DEPTH];
  logic [PAGES_W-1:0] slot_pages [TABLE_DEPTH];
  logic [ATTR_W-1:0]  slot_attrs [TABLE_DEPTH];
  int                 held_count;
  logic [ADDR_W-1:0]  win_base;
  logic [TOP_W-1:0]   win_top;

  region_reply_t pending_replies[$];
  int            errors = 0;

  assign fail_count = errors;

  function automatic logic [ADDR_W-1:0] slot_begin(int i);
    return {slot_page[i], 12'h000};
  endfunction

  function automatic logic [END_W-1:0] slot_limit(int i);
    return {2'b00, slot_page[i], 12'h000} + {1'b0, slot_pages[i], 12'h000};
  endfunction

  // Apply one command to the shadow table and build its result
  function automatic region_reply_t apply_region_cmd(urt_op_t op, logic [ADDR_W-1:0] addr,
                                                     logic [PAGES_W-1:0] pages,
                                                     logic [ATTR_W-1:0] attrs);
    region_reply_t     r;
    logic [ADDR_W-1:0] start;
    logic [END_W-1:0]  stop;
    int                hit;
    r = '0;
    r.status = ST_OK;
    start = {addr[ADDR_W-1:12], 12'h000};
    stop = {2'b00, start} + {1'b0, pages, 12'h000};
    hit = -1;
    case (op)
      OP_RESERVE: begin
        if (pages == '0) begin
          r.status = ST_ZERO;
        end else if (start < win_base || stop > {1'b0, win_top}) begin
          r.status = ST_WINDOW;
        end else begin
          for (int i = 0; i < held_count; i++) begin
            if (hit < 0 && {2'b00, start} < slot_limit(i) && stop > {2'b00, slot_begin(i)})
              hit = i;
          end
          if (hit >= 0) begin
            r.status = ST_OVERLAP;
          end else if (held_count >= TABLE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            slot_page[held_count]  = start[ADDR_W-1:12];
            slot_pages[held_count] = pages;
            slot_attrs[held_count] = attrs | PTE_US;
            held_count++;
          end
        end
      end
      OP_RELEASE: begin
        for (int i = 0; i < held_count; i++) begin
          if (hit < 0 && slot_begin(i) == start) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          // Move the last region into the freed slot
          slot_page[hit]  = slot_page[held_count-1];
          slot_pages[hit] = slot_pages[held_count-1];
          slot_attrs[hit] = slot_attrs[held_count-1];
          held_count--;
        end
      end
      OP_LOOKUP: begin
        for (int i = 0; i < held_count; i++) begin
          if (hit < 0 && addr >= slot_begin(i) && {2'b00, addr} < slot_limit(i)) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.found_start = slot_begin(hit);
          r.found_pages = slot_pages[hit];
          r.found_attrs = slot_attrs[hit];
        end
      end
      default: begin
        held_count = 0;
      end
    endcase
    r.live_count = held_count[LIVE_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Retire results first, then take configuration and new command items
  always @(posedge clk) begin
    region_reply_t want;
    if (!rst_n) begin
      held_count = 0;
      win_base = 47'h400000;
      win_top = 48'h7FFF_FFFF_F000;
      pending_replies.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_replies.size() == 0) begin
          $display("%0t: result item with none expected, expected none actual status %0d",
                   $time, out_ch.status);
          errors++;
        end else begin
          want = pending_replies.pop_front();
          check_field("status", 64'(want.status), 64'(out_ch.status));
          check_field("found_start", 64'(want.found_start), 64'(out_ch.found_start));
          check_field("found_pages", 64'(want.found_pages), 64'(out_ch.found_pages));
          check_field("found_attrs", want.found_attrs, out_ch.found_attrs);
          check_field("live_count", 64'(want.live_count), 64'(out_ch.live_count));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_BASE) win_base = cfg_ch.data[ADDR_W-1:0];
        else win_top = cfg_ch.data;
      end
      if (in_ch.valid && in_ch.ready)
        pending_replies.push_back(apply_region_cmd(in_ch.cmd, in_ch.addr, in_ch.page_count,
                                                   in_ch.region_attrs));
    end
    outstanding = pending_replies.size();
  end

endmodule

// ===== bench/user_region_table_test.sv =====
// ---------------------------------------------------------------------------
// user_region_table_test: testbench of the user region table
// Drives reserve, release, lookup and clear items through directed cases and
// random traffic under several user windows, with random idling on both
// sides and one long result stall; a checker beside the block compares.
// ---------------------------------------------------------------------------
module user_region_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import urt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 500;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   outstanding;
  int   cycle_count = 0;
  bit   idle_on = 1'b1;
  bit   quiet = 1'b0;
  bit   hold_req = 1'b0;
  bit   hold_done = 1'b0;
  bit   hold_taken = 1'b0;

  logic [ADDR_W-1:0] recent_addr [32];
  int                recent_n = 0;

  urt_in_if  in_ch ();
  urt_out_if out_ch ();
  urt_cfg_if cfg_ch ();

  user_region_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  urt_region_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("user_region_table: mismatch");
      $finish;
    end
  end

  // Result side: random stall bursts, one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one command item and hold it until accepted; valid stays high
  task automatic send_cmd(urt_op_t op, logic [ADDR_W-1:0] addr, logic [PAGES_W-1:0] pages,
                          logic [ATTR_W-1:0] attrs);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= op;
    in_ch.addr         <= addr;
    in_ch.page_count   <= pages;
    in_ch.region_attrs <= attrs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(urt_cfg_idx_t idx, logic [TOP_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Let the table go idle, then move the user window
  task automatic set_window(logic [TOP_W-1:0] base, logic [TOP_W-1:0] top);
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    write_reg(CFG_BASE, base);
    write_reg(CFG_TOP, top);
    cfg_ch.valid <= 1'b0;
    recent_n = 0;
  endtask

  function automatic logic [ADDR_W-1:0] recall_addr(logic [ADDR_W-1:0] zone);
    if (recent_n == 0) return zone;
    return recent_addr[$urandom_range(0, (recent_n < 32 ? recent_n : 32) - 1)];
  endfunction

  // Mostly well-formed traffic around a zone, some noise items
  task automatic random_cmd(logic [ADDR_W-1:0] zone);
    int                 pick;
    int                 r;
    logic [63:0]        wide;
    logic [ADDR_W-1:0]  a;
    logic [PAGES_W-1:0] pg;
    logic [ATTR_W-1:0]  at;
    pick = $urandom_range(0, 99);
    wide = {$urandom, $urandom};
    at = {$urandom, $urandom};
    a = zone + ADDR_W'($urandom_range(0, 63)) * 47'h1000 + ADDR_W'($urandom_range(0, 4095));
    pg = PAGES_W'($urandom_range(1, 12));
    if (pick < 6) begin
      pg = {4'($urandom_range(0, 15)), $urandom};
      send_cmd(urt_op_t'($urandom_range(0, 3)), wide[ADDR_W-1:0], pg, at);
    end else if (pick < 48) begin
      r = $urandom_range(0, 19);
      if (r == 0) pg = '0;
      else if (r == 1) pg = {4'($urandom_range(0, 15)), $urandom};
      else if (r == 2) pg = 36'h8_0000_0000;
      recent_addr[recent_n % 32] = a;
      recent_n++;
      send_cmd(OP_RESERVE, a, pg, at);
    end else if (pick < 76) begin
      a = recall_addr(zone) + ADDR_W'($urandom_range(0, 16 * 4096 - 1));
      send_cmd(OP_LOOKUP, a, wide[PAGES_W-1:0], at);
    end else if (pick < 97) begin
      if ($urandom_range(0, 3) != 0)
        a = (recall_addr(zone) & ~ADDR_W'(12'hFFF)) + ADDR_W'($urandom_range(0, 4095));
      send_cmd(OP_RELEASE, a, wide[PAGES_W-1:0], at);
    end else begin
      send_cmd(OP_CLEAR, wide[ADDR_W-1:0], pg, at);
    end
  endtask

  task automatic random_run(logic [ADDR_W-1:0] zone, int count);
    for (int k = 0; k < count; k++) begin
      idle_on = !quiet && ((k / 40) % 5 != 4);
      if (!hold_done && k == 120) begin
        hold_done = 1'b1;
        hold_req = 1'b1;
      end
      random_cmd(zone);
    end
  endtask

  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.cmd           <= OP_RESERVE;
    in_ch.addr          <= '0;
    in_ch.page_count    <= '0;
    in_ch.region_attrs  <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= CFG_BASE;
    cfg_ch.data         <= '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty table, reserve checks in order, exact end at the window top
    send_cmd(OP_LOOKUP, 47'h400000, '0, '0);
    send_cmd(OP_RELEASE, 47'h400000, '0, '0);
    send_cmd(OP_CLEAR, '0, '0, '0);
    send_cmd(OP_RESERVE, 47'h400000, '0, '1);
    send_cmd(OP_RESERVE, 47'h3FF000, 36'd1, '1);
    send_cmd(OP_RESERVE, 47'h7FFF_FFFF_E000, 36'd2, '1);
    send_cmd(OP_RESERVE, 47'h7FFF_FFFF_EFFF, 36'd1, '1);
    send_cmd(OP_RESERVE, 47'h400ABC, 36'd16, '0);
    send_cmd(OP_RESERVE, 47'h40F000, 36'd1, '1);
    send_cmd(OP_RESERVE, 47'h410000, 36'd1, 64'h8000_0000_0000_0000);
    send_cmd(OP_LOOKUP, 47'h40FFFF, '1, '1);
    send_cmd(OP_RELEASE, 47'h400FFF, '0, '0);

    // Fill the table; overlap wins over full, then full
    for (int k = 0; k < 15; k++)
      send_cmd(OP_RESERVE, 47'h100_0000 + ADDR_W'(k) * 47'h1_0000, PAGES_W'(k + 1),
               {$urandom, $urandom});
    send_cmd(OP_RESERVE, 47'h100_0000, 36'd1, '0);
    send_cmd(OP_RESERVE, 47'h200_0000, 36'd1, '0);
    send_cmd(OP_LOOKUP, 47'h10D_FFFF, '0, '0);

    random_run(47'h40_0000, 400);

    // Widest window with the largest page counts
    set_window(48'h0, 48'h8000_0000_0000);
    send_cmd(OP_CLEAR, '0, '0, '0);
    send_cmd(OP_RESERVE, '0, 36'h8_0000_0000, '0);
    send_cmd(OP_LOOKUP, 47'h7FFF_FFFF_FFFF, '0, '0);
    send_cmd(OP_RESERVE, 47'h1000, '1, '1);
    send_cmd(OP_RELEASE, 47'h0FFF, '0, '0);
    random_run(47'h0, 380);

    // Window at the top of the address range, top above the largest address
    set_window(48'h7FFF_FFF0_0000, 48'hFFFF_FFFF_FFFF);
    random_run(47'h7FFF_FFF0_0000, 380);

    // Base above top: every reserve is rejected
    set_window(48'hFFFF_FFFF_FFFF, 48'h0);
    random_run(47'h7FFF_FFF0_0000, 100);

    // Small window, no idling to the end
    set_window(48'h1000_0000, 48'h1004_0000);
    quiet = 1'b1;
    random_run(47'h1000_0000, 400);

    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (fail_count == 0) begin
      $display("user_region_table: match");
    end else begin
      $display("user_region_table: mismatch");
    end
    $finish;
  end

endmodule
